FILE: hdl/packet_coherent_averager_core_defines.svh
// Assertion macros for the packet coherent averager.
// Used by pca_div and packet_coherent_averager_core; expects clk and arst_n in scope.
`ifndef PACKET_COHERENT_AVERAGER_CORE_DEFINES_SVH
`define PACKET_COHERENT_AVERAGER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PCA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define PCA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define PCA_ASSERT(lbl, prop, msg)
`define PCA_NEVER(lbl, cond, msg)
`endif
`endif

FILE: hdl/pca_pkg.sv
// Shared types and constants for the packet coherent averager.
// No dependencies.
`default_nettype none
package pca_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHTED_MODE = 2'd1;

	localparam int unsigned DIV_STEPS = 64;
	localparam int unsigned SCALE_LAT = 4;

	typedef struct packed {
		logic signed [31:0] sample;
		logic signed [31:0] weight;
		logic               present;
		logic               last;
		logic               reset_now;
		logic signed [31:0] reset_scale;
	} in_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic signed [63:0] count;
		logic               last_out;
	} out_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_OUT,
		ST_SCALE
	} state_t;

endpackage
`default_nettype wire

FILE: hdl/pca_div.sv
// Iterative signed 64-bit divider, one quotient bit per cycle, truncating.
// Depends on pca_pkg and the assertion macro header.
`default_nettype none
`include "packet_coherent_averager_core_defines.svh"
module pca_div
	import pca_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] num,
	input  wire logic [63:0] den,
	output logic             done,
	output logic [63:0]      quo
);

	localparam int unsigned CW = $clog2(DIV_STEPS + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [63:0]   dvd_q;
	logic [63:0]   dvs_q;
	logic [63:0]   rem_q;
	logic [63:0]   quo_q;
	logic [64:0]   shifted;
	logic [64:0]   diff;

	// restoring step
	assign shifted = {rem_q, dvd_q[63]};
	assign diff    = shifted - {1'b0, dvs_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIV_STEPS);
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end else begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= num[63] ? (64'd0 - num) : num;
			dvs_q <= den[63] ? (64'd0 - den) : den;
			rem_q <= '0;
			neg_q <= num[63] ^ den[63];
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				if (!diff[64]) begin
					rem_q <= diff[63:0];
					dvd_q <= {dvd_q[62:0], 1'b1};
				end else begin
					rem_q <= shifted[63:0];
					dvd_q <= {dvd_q[62:0], 1'b0};
				end
			end else begin
				quo_q <= neg_q ? (64'd0 - dvd_q) : dvd_q;
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

	`PCA_NEVER(a_div_start_busy, start && busy_q, "divider restarted while busy")
	`PCA_ASSERT(a_div_done_pulse, done_q |=> !done_q, "divider done longer than one cycle")
	`PCA_ASSERT(a_div_done_src, $rose(done_q) |-> $past(busy_q), "divider done without a run")

endmodule
`default_nettype wire

FILE: hdl/pca_scale.sv
// Four-stage Q16.16 scaler: (a * s) / 2^16 truncated toward zero, 64-bit wrap.
// No dependencies.
`default_nettype none
module pca_scale (
	input  wire logic        clk,
	input  wire logic [63:0] a,
	input  wire logic [31:0] s_mag,
	input  wire logic        s_neg,
	output logic [63:0]      r
);

	logic [63:0] ma_s1;
	logic        neg_s1;
	logic [63:0] p0_s2;
	logic [63:0] p1_s2;
	logic        neg_s2;
	logic [63:0] r_s3;
	logic        neg_s3;
	logic [63:0] r_s4;

	// magnitude, two partial products, recombine, sign
	always_ff @(posedge clk) begin
		ma_s1  <= a[63] ? (64'd0 - a) : a;
		neg_s1 <= a[63] ^ s_neg;
		p0_s2  <= 64'(ma_s1[31:0]) * 64'(s_mag);
		p1_s2  <= 64'(ma_s1[63:32]) * 64'(s_mag);
		neg_s2 <= neg_s1;
		r_s3   <= {16'd0, p0_s2[63:16]} + {p1_s2[47:0], 16'd0};
		neg_s3 <= neg_s2;
		r_s4   <= neg_s3 ? (64'd0 - r_s3) : r_s3;
	end

	assign r = r_s4;

endmodule
`default_nettype wire

FILE: hdl/packet_coherent_averager_core.sv
// Packet coherent averager: per-position sum and count memory with sequencer.
// Depends on pca_pkg, pca_div, pca_scale and the assertion macro header.
`default_nettype none
`include "packet_coherent_averager_core_defines.svh"
// Each beat on in_data is one packet sample; it is added into the sum and
// count held for its position, and one result beat gives that entry (or the
// sum divided by the count in average mode, when the count is nonzero). Both
// live in one DEPTH-entry memory, read (registered) and then written back once
// per item; a new beat is taken only once the previous item is done. When a
// division is needed the serial divider runs before the result is given. A
// beat with reset_now then sweeps the memory through the four-stage scaler.
// After reset the memory is cleared in a pass during which no sample is taken;
// configuration writes are accepted at any time.
module packet_coherent_averager_core
	import pca_pkg::*;
#(
	parameter int unsigned DEPTH        = 1024,
	parameter int unsigned SAMPLE_WIDTH = 32
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire in_t                  in_data,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output out_t                      out_data
);

	localparam int unsigned AW = $clog2(DEPTH);

	state_t state_q, state_d;

	logic avg_mode_q, wgt_mode_q;
	logic [AW-1:0] pos_q;
	logic [AW:0]   scan_q;
	logic          scan_left;

	// memory: {sum, count}
	logic [127:0]  mem [DEPTH];
	logic [127:0]  rd_q;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [127:0]  wr_data;

	// item registers
	logic [AW-1:0] addr_s1;
	logic [63:0]   add_sum_s1, add_cnt_s1;
	logic          avg_s1, last_s1, rst_s1, sc_neg_s1;
	logic [31:0]   sc_mag_s1;
	logic [63:0]   sum_s2, cnt_s2;
	logic          div_hit_q;

	// output register
	logic out_valid_q;
	out_t out_q;
	logic out_free, out_load;
	out_t out_next;

	logic accept;
	logic [63:0] sum_new, cnt_new;
	logic need_div;
	logic div_start, div_done;
	logic [63:0] div_quo;

	// scale sweep pipeline
	logic [SCALE_LAT:0] swp_v_q;
	logic [AW-1:0]      swp_addr_q [SCALE_LAT+1];
	logic [63:0]        sc_sum, sc_cnt;

	// sample and addend
	logic signed [SAMPLE_WIDTH-1:0] smp_n;
	logic signed [63:0]             smp_ext;
	logic signed [31:0]             s32, w32;
	logic signed [63:0]             prod;

	assign smp_n   = in_data.sample[SAMPLE_WIDTH-1:0];
	assign smp_ext = 64'(smp_n);
	assign s32     = smp_ext[31:0];
	assign w32     = in_data.weight;
	assign prod    = 64'(s32) * 64'(w32);

	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign scan_left = (scan_q != (AW+1)'(DEPTH));
	assign sum_new   = rd_q[127:64] + add_sum_s1;
	assign cnt_new   = rd_q[63:0] + add_cnt_s1;
	assign need_div  = avg_s1 && (cnt_new != 64'd0);

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_mode_q <= 1'b0;
			wgt_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			if (cfg_index == REG_AVERAGE_MODE) avg_mode_q <= cfg_data[0];
			if (cfg_index == REG_WEIGHTED_MODE) wgt_mode_q <= cfg_data[0];
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    if (!scan_left) state_d = ST_IDLE;
			ST_IDLE:     if (in_valid) state_d = ST_READ;
			ST_READ: begin
				if (need_div) state_d = ST_DIV_GO;
				else if (!out_free) state_d = ST_OUT;
				else state_d = rst_s1 ? ST_SCALE : ST_IDLE;
			end
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_OUT;
			ST_OUT:      if (out_free) state_d = rst_s1 ? ST_SCALE : ST_IDLE;
			ST_SCALE:    if (!scan_left && (swp_v_q == '0)) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = pos_q;
		wr_en     = 1'b0;
		wr_addr   = addr_s1;
		wr_data   = {sum_new, cnt_new};
		out_load  = 1'b0;
		div_start = 1'b0;
		out_next  = '{value: sum_new, count: cnt_new, last_out: last_s1};
		unique case (state_q)
			ST_CLEAR: begin
				wr_en   = scan_left;
				wr_addr = scan_q[AW-1:0];
				wr_data = '0;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_en    = in_valid;
			end
			ST_READ: begin
				wr_en    = 1'b1;
				out_load = !need_div && out_free;
			end
			ST_DIV_GO:   div_start = 1'b1;
			ST_DIV_WAIT: ;
			ST_OUT: begin
				out_load = out_free;
				out_next = '{value: (div_hit_q ? div_quo : sum_s2), count: cnt_s2,
					last_out: last_s1};
			end
			ST_SCALE: begin
				rd_en   = scan_left;
				rd_addr = scan_q[AW-1:0];
				wr_en   = swp_v_q[SCALE_LAT];
				wr_addr = swp_addr_q[SCALE_LAT];
				wr_data = {sc_sum, sc_cnt};
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			swp_v_q     <= '0;
		end else begin
			state_q <= state_d;
			if (state_d == ST_SCALE && state_q != ST_SCALE) scan_q <= '0;
			else if ((state_q == ST_CLEAR || state_q == ST_SCALE) && scan_left)
				scan_q <= scan_q + 1'b1;
			if (accept)
				pos_q <= (in_data.last || pos_q == AW'(DEPTH - 1)) ? '0 : pos_q + 1'b1;
			if (out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			swp_v_q <= {swp_v_q[SCALE_LAT-1:0], (state_q == ST_SCALE) && scan_left};
		end
	end

	// memory
	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	// item, result and sweep payload
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1    <= pos_q;
			add_sum_s1 <= !in_data.present ? 64'd0 : (wgt_mode_q ? prod : smp_ext);
			add_cnt_s1 <= !in_data.present ? 64'd0 :
				(wgt_mode_q ? 64'(in_data.weight) : 64'd1);
			avg_s1     <= avg_mode_q;
			last_s1    <= in_data.last;
			rst_s1     <= in_data.reset_now;
			sc_neg_s1  <= in_data.reset_scale[31];
			sc_mag_s1  <= in_data.reset_scale[31] ? (32'd0 - in_data.reset_scale)
				: in_data.reset_scale;
		end
		if (state_q == ST_READ) begin
			sum_s2    <= sum_new;
			cnt_s2    <= cnt_new;
			div_hit_q <= need_div;
		end
		if (out_load) out_q <= out_next;
		swp_addr_q[0] <= scan_q[AW-1:0];
		for (int i = 1; i <= SCALE_LAT; i++) swp_addr_q[i] <= swp_addr_q[i-1];
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	pca_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (sum_s2),
		.den    (cnt_s2),
		.done   (div_done),
		.quo    (div_quo)
	);

	pca_scale u_scale_sum (
		.clk   (clk),
		.a     (rd_q[127:64]),
		.s_mag (sc_mag_s1),
		.s_neg (sc_neg_s1),
		.r     (sc_sum)
	);

	pca_scale u_scale_cnt (
		.clk   (clk),
		.a     (rd_q[63:0]),
		.s_mag (sc_mag_s1),
		.s_neg (sc_neg_s1),
		.r     (sc_cnt)
	);

	`PCA_NEVER(a_idle_no_write, (state_q == ST_IDLE) && wr_en, "memory written while idle")
	`PCA_ASSERT(a_accept_read, accept |=> (state_q == ST_READ), "accepted beat not read")
	`PCA_ASSERT(a_done_wait, div_done |-> (state_q == ST_DIV_WAIT), "divide result unexpected")

endmodule
`default_nettype wire

FILE: sim/packet_coherent_averager_core_checker.sv
// Checker for the packet coherent averager: watches the config, sample and result
// channels, predicts every result beat and compares it. Depends on pca_pkg.
`default_nettype none
module packet_coherent_averager_core_checker
	import pca_pkg::*;
#(
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	input  wire logic                 cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data,
	input  wire logic                 in_valid,
	input  wire logic                 in_ready,
	input  wire in_t                  in_data,
	input  wire logic                 out_valid,
	input  wire logic                 out_ready,
	input  wire out_t                 out_data,
	output int                        errors,
	output int                        pending
);

	// Own copy of the accumulator state and mode bits
	logic [63:0] sum_mem [DEPTH];
	logic [63:0] cnt_mem [DEPTH];
	int unsigned pos;
	bit          avg_on;
	bit          wgt_on;
	out_t        awaited_results[$];

	function automatic logic [63:0] mag64(logic [63:0] x);
		return x[63] ? -x : x;
	endfunction

	// Signed division truncating toward zero; min / -1 wraps to min
	function automatic logic [63:0] div_toward_zero(logic [63:0] n, logic [63:0] d);
		logic [63:0] q;
		q = mag64(n) / mag64(d);
		return (n[63] != d[63]) ? -q : q;
	endfunction

	// Entry times Q16.16 factor, exact product, truncated toward zero, wrapped
	function automatic logic [63:0] q16_scaled(logic [63:0] a, logic [31:0] s);
		logic [127:0] p;
		logic [63:0]  r;
		p = 128'(mag64(a)) * 128'(mag64({{32{s[31]}}, s}));
		r = p[79:16];
		return (a[63] != s[31]) ? -r : r;
	endfunction

	// Accumulate one sample beat and work out its result beat
	function automatic out_t accumulate_sample(in_t d);
		out_t        res;
		logic [63:0] smp;
		logic [63:0] wgt;
		int unsigned idx;
		idx = pos;
		smp = {{32{d.sample[31]}}, d.sample};
		wgt = {{32{d.weight[31]}}, d.weight};
		if (d.present) begin
			if (wgt_on) begin
				sum_mem[idx] = sum_mem[idx] + smp * wgt;
				cnt_mem[idx] = cnt_mem[idx] + wgt;
			end else begin
				sum_mem[idx] = sum_mem[idx] + smp;
				cnt_mem[idx] = cnt_mem[idx] + 64'd1;
			end
		end
		res.value = sum_mem[idx];
		if (avg_on && cnt_mem[idx] != 64'd0)
			res.value = div_toward_zero(sum_mem[idx], cnt_mem[idx]);
		res.count    = cnt_mem[idx];
		res.last_out = d.last;
		if (d.reset_now) begin
			for (int j = 0; j < DEPTH; j++) begin
				sum_mem[j] = q16_scaled(sum_mem[j], d.reset_scale);
				cnt_mem[j] = q16_scaled(cnt_mem[j], d.reset_scale);
			end
		end
		pos = (d.last || idx + 1 >= DEPTH) ? 0 : idx + 1;
		return res;
	endfunction

	initial begin
		for (int j = 0; j < DEPTH; j++) begin
			sum_mem[j] = '0;
			cnt_mem[j] = '0;
		end
		pos     = 0;
		avg_on  = 0;
		wgt_on  = 0;
		errors  = 0;
		pending = 0;
	end

	// Watch all three channels on the rising edge
	always @(posedge clk) begin
		out_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_AVERAGE_MODE)
					avg_on = cfg_data[0];
				else if (cfg_index == REG_WEIGHTED_MODE)
					wgt_on = cfg_data[0];
			end
			if (in_valid && in_ready)
				awaited_results.push_back(accumulate_sample(in_data));
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat value %h count %h last %b",
						$time, out_data.value, out_data.count, out_data.last_out);
				end else begin
					want = awaited_results.pop_front();
					if (out_data.value !== want.value) begin
						errors++;
						$display("%0t: value mismatch, expected %h, got %h",
							$time, want.value, out_data.value);
					end
					if (out_data.count !== want.count) begin
						errors++;
						$display("%0t: count mismatch, expected %h, got %h",
							$time, want.count, out_data.count);
					end
					if (out_data.last_out !== want.last_out) begin
						errors++;
						$display("%0t: last_out mismatch, expected %b, got %b",
							$time, want.last_out, out_data.last_out);
					end
				end
			end
			pending = awaited_results.size();
		end
	end

endmodule
`default_nettype wire

FILE: sim/packet_coherent_averager_core_tb.sv
// Testbench top for the packet coherent averager: clock, reset, stimulus and verdict.
// Depends on pca_pkg, the core and packet_coherent_averager_core_checker.
`default_nettype none
module packet_coherent_averager_core_tb;
	import pca_pkg::*;

	localparam int unsigned DEPTH     = 1024;
	localparam int unsigned SETTLE    = DEPTH + 100;
	localparam int unsigned LONG_HOLD = 600;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	logic                 in_valid;
	logic                 in_ready;
	in_t                  in_data;
	logic                 out_valid;
	logic                 out_ready;
	out_t                 out_data;
	int                   errors;
	int                   pending;
	logic                 cfg_fire;
	logic                 in_fire;
	logic                 out_fire;
	bit                   sender_no_gaps;

	packet_coherent_averager_core #(.DEPTH(DEPTH), .SAMPLE_WIDTH(32)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	packet_coherent_averager_core_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Handshake flags, read back at the falling edge
	always @(posedge clk) begin
		cfg_fire <= cfg_valid && cfg_ready;
		in_fire  <= in_valid && in_ready;
		out_fire <= out_valid && out_ready;
	end

	initial begin
		#1500000;
		$display("simulation failed");
		$finish;
	end

	function automatic in_t mk_beat(logic [31:0] smp, logic [31:0] wgt, bit present,
			bit last, bit rst, logic [31:0] scale);
		in_t b;
		b.sample      = smp;
		b.weight      = wgt;
		b.present     = present;
		b.last        = last;
		b.reset_now   = rst;
		b.reset_scale = scale;
		return b;
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($signed($urandom_range(0, 200)) - 100);
			3: return 32'h0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_scale();
		case ($urandom_range(0, 6))
			0: return 32'h0;
			1: return 32'h0001_0000;
			2: return 32'h0000_8000;
			3: return 32'hffff_0000;
			4: return 32'h8000_0000;
			5: return 32'h7fff_ffff;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_beat(in_t b);
		int gap;
		gap = sender_no_gaps ? 0 : $urandom_range(0, 14);
		repeat (gap) @(negedge clk);
		in_valid = 1;
		in_data  = b;
		do @(negedge clk); while (!in_fire);
		in_valid = 0;
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_valid = 1;
		cfg_index = idx;
		cfg_data  = val;
		do @(negedge clk); while (!cfg_fire);
		cfg_valid = 0;
	endtask

	// Drain, let any scale pass finish, then reprogram both modes
	task automatic set_modes(bit avg, bit wgt);
		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		write_reg(REG_AVERAGE_MODE, {31'($urandom), avg});
		write_reg(REG_WEIGHTED_MODE, {31'($urandom), wgt});
	endtask

	// Random packets, mostly well formed
	task automatic random_packets(int n_items);
		int sent;
		int len;
		bit stray_last;
		sent = 0;
		while (sent < n_items) begin
			len = $urandom_range(1, 16);
			sender_no_gaps = ($urandom_range(0, 2) == 0);
			if ($urandom_range(0, 9) == 0)
				while (pending != 0) @(negedge clk);
			for (int k = 0; k < len; k++) begin
				stray_last = ($urandom_range(0, 15) == 0);
				send_beat(mk_beat(pick_word(), pick_word(), $urandom_range(0, 7) != 0,
					(k == len - 1) || stray_last, $urandom_range(0, 39) == 0,
					pick_scale()));
				sent++;
			end
		end
	endtask

	// Result side: random stalls in stretches, plus one long hold-off
	initial begin
		int beats;
		int wait_cycles;
		bit stall_on;
		out_ready = 0;
		beats     = 0;
		stall_on  = 1;
		@(posedge arst_n);
		forever begin
			if (beats % 64 == 0)
				stall_on = $urandom_range(0, 2) != 0;
			wait_cycles = stall_on ? $urandom_range(0, 14) : 0;
			if (beats == 300)
				wait_cycles = LONG_HOLD;
			@(negedge clk);
			out_ready = 0;
			repeat (wait_cycles) @(negedge clk);
			out_ready = 1;
			do @(negedge clk); while (!out_fire);
			beats++;
		end
	end

	initial begin
		in_valid       = 0;
		in_data        = '0;
		cfg_valid      = 0;
		cfg_index      = REG_AVERAGE_MODE;
		cfg_data       = '0;
		sender_no_gaps = 0;
		arst_n         = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// Directed: raw sums, extremes, absent read, reset scaling
		write_reg(REG_AVERAGE_MODE, 32'd0);
		write_reg(REG_WEIGHTED_MODE, 32'd0);
		send_beat(mk_beat(32'h7fff_ffff, 32'h0, 1, 0, 0, 32'h0));
		send_beat(mk_beat(32'h8000_0000, 32'hffff_ffff, 1, 0, 0, 32'h0));
		send_beat(mk_beat(32'h1234_5678, 32'h0, 0, 0, 0, 32'h0));
		send_beat(mk_beat(32'hffff_ffff, 32'h0, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h7fff_ffff, 32'h0, 1, 1, 1, 32'h0001_0000));
		send_beat(mk_beat(32'h0000_0005, 32'h0, 1, 1, 1, 32'h7fff_ffff));
		send_beat(mk_beat(32'h8000_0000, 32'h0, 1, 1, 1, 32'h8000_0000));
		send_beat(mk_beat(32'h0000_0001, 32'h0, 1, 1, 1, 32'h0));

		// Weighted average: build sum = most negative, count = -1 at position 0
		set_modes(1, 1);
		send_beat(mk_beat(32'h8000_0000, 32'h8000_0000, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h8000_0000, 32'h8000_0000, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h0, 32'h7fff_ffff, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h0, 32'h7fff_ffff, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h0, 32'h0000_0001, 1, 1, 0, 32'h0));
		// zero count falls back to the raw sum, then clear everything
		send_beat(mk_beat(32'h0000_0005, 32'h0000_0001, 1, 1, 1, 32'h0));
		// truncation toward zero: -7 / 2
		send_beat(mk_beat(32'hffff_fff9, 32'h0000_0001, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h0, 32'h0000_0001, 1, 1, 0, 32'h0));
		send_beat(mk_beat(32'h0, 32'h0000_0001, 0, 1, 0, 32'h0));

		// One packet longer than the store, back to back, to wrap and fill
		set_modes(0, 0);
		sender_no_gaps = 1;
		for (int k = 0; k < DEPTH + 6; k++)
			send_beat(mk_beat(pick_word(), pick_word(), $urandom_range(0, 7) != 0,
				k == DEPTH + 5, 0, 32'h0));
		sender_no_gaps = 0;

		set_modes(1, 0);
		random_packets(25);
		set_modes(0, 1);
		random_packets(25);
		set_modes(1, 1);
		random_packets(25);
		set_modes(0, 0);
		random_packets(25);

		while (pending != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
		if (errors == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
`default_nettype wire
